// ----- rtl/core/pbra_pkg.sv -----
`default_nettype none

package pbra_pkg;

   localparam int NUM_PAGES       = 16;
   localparam int BLOCKS_PER_PAGE = 64;
   localparam int BLOCK_BYTES     = 64;
   localparam int HDR_BYTES       = 16;
   localparam int PAGE_BYTES      = BLOCKS_PER_PAGE * BLOCK_BYTES;
   localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);
   localparam int PAGE_W          = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

   // run search: one power-of-two step per cycle, longest run: one byte lane per cycle
   localparam int FIT_STEPS  = 7;
   localparam int LRUN_LANE  = 8;
   localparam int LRUN_STEPS = BLOCKS_PER_PAGE / LRUN_LANE;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_BAD_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FIT,
      S_MARK,
      S_LRUN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       scan_step;
      logic       fit_start;
      logic       fit_step;
      logic       mark;
      logic       lrun_step;
      logic       set_status;
      status_type status;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_release;
      logic too_large;
      logic bad_range;
      logic page_fits;
      logic scan_last;
      logic fit_last;
      logic lrun_last;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/pbra_ctrl.sv -----
`default_nettype none

module pbra_ctrl
   import pbra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_release) begin
               if (stat.bad_range) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_BAD_RANGE;
                  state_in       = S_FINISH;
               end else begin
                  cmd.mark = 1'b1;
                  state_in = S_LRUN;
               end
            end else if (stat.too_large) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_TOO_LARGE;
               state_in       = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.page_fits) begin
               cmd.fit_start = 1'b1;
               state_in      = S_FIT;
            end else if (stat.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_FIT;
               state_in       = S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FIT: begin
            cmd.fit_step = 1'b1;
            if (stat.fit_last) begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            state_in = S_LRUN;
         end
         S_LRUN: begin
            cmd.lrun_step = 1'b1;
            if (stat.lrun_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/pbra_dpath.sv -----
`default_nettype none

module pbra_dpath
   import pbra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   input  wire logic        req_cmd,
   input  wire logic [19:0] req_size_bytes,
   input  wire logic [3:0]  req_page_index,
   input  wire logic [5:0]  req_first_block,
   input  wire logic [6:0]  req_block_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output status_type       rsp_status,
   output logic [3:0]       rsp_page_index_out,
   output logic [5:0]       rsp_first_block_out,
   output logic [6:0]       rsp_blocks_used,
   output logic [15:0]      rsp_byte_offset
);

   function automatic logic [63:0] run_mask(input logic [6:0] count, input logic [5:0] first);
      logic [63:0] m;
      begin
         m = (count >= 7'(BLOCKS_PER_PAGE)) ? '1 : ((64'd1 << count) - 64'd1);
         return m << first;
      end
   endfunction

   function automatic logic [5:0] lowest_set(input logic [63:0] v);
      logic [5:0] idx;
      begin
         idx = '0;
         for (int i = 63; i >= 0; i--) begin
            if (v[i]) idx = 6'(i);
         end
         return idx;
      end
   endfunction

   // page state
   logic [63:0] map_ff [NUM_PAGES];
   logic [6:0]  lfr_ff [NUM_PAGES];

   // latched request
   logic        is_rel_ff;
   logic        too_large_ff;
   logic [6:0]  cnt_ff;
   logic [3:0]  rpage_ff;
   logic [5:0]  rblock_ff;

   // working registers
   logic [PAGE_W-1:0] page_ff;
   logic [5:0]        block_ff;
   logic [63:0]       pw_ff, acc_ff, wmap_ff;
   logic [6:0]        cur_ff, lcur_ff, lbest_ff;
   logic [2:0]        step_ff;
   status_type        status_ff;

   // result register
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [3:0]        rsp_page_ff;
   logic [5:0]        rsp_block_ff;
   logic [6:0]        rsp_count_ff;
   logic [15:0]       rsp_offset_ff;

   // request decode
   logic [20:0] hdr_sum;
   logic [15:0] need;
   logic [7:0]  rel_end;

   assign hdr_sum = {1'b0, req_size_bytes} + 21'(HDR_BYTES);
   assign need    = 16'(hdr_sum >> BLOCK_SHIFT) + 16'd1;
   assign rel_end = {2'b00, rblock_ff} + {1'b0, cnt_ff};

   // fit step
   logic [6:0]  pow;
   logic [63:0] acc_next;
   logic [6:0]  cur_next;

   assign pow = 7'd1 << step_ff;

   always_comb begin
      acc_next = acc_ff;
      cur_next = cur_ff;
      if (cnt_ff[step_ff]) begin
         acc_next = acc_ff & (pw_ff >> cur_ff);
         cur_next = cur_ff + pow;
      end
   end

   // mark
   logic [PAGE_W-1:0] mark_page;
   logic [5:0]        mark_block;
   logic [63:0]       mark_mask;
   logic [63:0]       mark_old;
   logic [63:0]       mark_new;

   assign mark_page  = is_rel_ff ? PAGE_W'(rpage_ff) : page_ff;
   assign mark_block = is_rel_ff ? rblock_ff : lowest_set(acc_ff);
   assign mark_mask  = run_mask(cnt_ff, mark_block);
   assign mark_old   = map_ff[mark_page];
   assign mark_new   = is_rel_ff ? (mark_old & ~mark_mask) : (mark_old | mark_mask);

   // longest run, one byte lane a cycle
   logic [LRUN_LANE-1:0] lane;
   logic [6:0]           lc, lb;

   assign lane = wmap_ff[{step_ff, 3'b000} +: LRUN_LANE];

   always_comb begin
      lc = lcur_ff;
      lb = lbest_ff;
      for (int i = 0; i < LRUN_LANE; i++) begin
         if (!lane[i]) begin
            lc = lc + 7'd1;
            if (lc > lb) lb = lc;
         end else begin
            lc = '0;
         end
      end
   end

   assign stat.is_release = is_rel_ff;
   assign stat.too_large  = too_large_ff;
   assign stat.bad_range  = (32'(rpage_ff) >= NUM_PAGES) || (cnt_ff == 7'd0) ||
                            (cnt_ff > 7'(BLOCKS_PER_PAGE)) || (rel_end > 8'(BLOCKS_PER_PAGE));
   assign stat.page_fits  = lfr_ff[page_ff] >= cnt_ff;
   assign stat.scan_last  = page_ff == PAGE_W'(NUM_PAGES - 1);
   assign stat.fit_last   = step_ff == 3'(FIT_STEPS - 1);
   assign stat.lrun_last  = step_ff == 3'(LRUN_STEPS - 1);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PAGES; p++) begin
            map_ff[p] <= '0;
            lfr_ff[p] <= 7'(BLOCKS_PER_PAGE);
         end
      end else begin
         if (cmd.mark) begin
            map_ff[mark_page] <= mark_new;
         end
         if (cmd.lrun_step && stat.lrun_last) begin
            lfr_ff[page_ff] <= lb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_rel_ff    <= req_cmd == CMD_RELEASE;
         too_large_ff <= need > 16'(BLOCKS_PER_PAGE);
         cnt_ff       <= (req_cmd == CMD_RELEASE) ? req_block_count : 7'(need);
         rpage_ff     <= req_page_index;
         rblock_ff    <= req_first_block;
         page_ff      <= '0;
      end
      if (cmd.scan_step) begin
         page_ff <= page_ff + PAGE_W'(1);
      end
      if (cmd.fit_start) begin
         pw_ff   <= ~map_ff[page_ff];
         acc_ff  <= '1;
         cur_ff  <= '0;
         step_ff <= '0;
      end
      if (cmd.fit_step) begin
         pw_ff   <= pw_ff & (pw_ff >> pow);
         acc_ff  <= acc_next;
         cur_ff  <= cur_next;
         step_ff <= step_ff + 3'd1;
      end
      if (cmd.mark) begin
         page_ff  <= mark_page;
         block_ff <= mark_block;
         wmap_ff  <= mark_new;
         lcur_ff  <= '0;
         lbest_ff <= '0;
         step_ff  <= '0;
      end
      if (cmd.lrun_step) begin
         lcur_ff  <= lc;
         lbest_ff <= lb;
         step_ff  <= step_ff + 3'd1;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         if (status_ff == ST_OK) begin
            rsp_page_ff   <= 4'(page_ff);
            rsp_block_ff  <= block_ff;
            rsp_count_ff  <= cnt_ff;
            rsp_offset_ff <= 16'(32'(page_ff) * PAGE_BYTES + 32'(block_ff) * BLOCK_BYTES
                                 + HDR_BYTES);
         end else begin
            rsp_page_ff   <= '0;
            rsp_block_ff  <= '0;
            rsp_count_ff  <= '0;
            rsp_offset_ff <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_page_index_out  = rsp_page_ff;
   assign rsp_first_block_out = rsp_block_ff;
   assign rsp_blocks_used     = rsp_count_ff;
   assign rsp_byte_offset     = rsp_offset_ff;

   a_fit_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.mark && !is_rel_ff) |-> (acc_ff != 64'd0))
      else $error("no fitting run in chosen page");

   a_run_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.mark && !is_rel_ff) |-> ((mark_old & mark_mask) == 64'd0))
      else $error("allocated run overlaps used blocks");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status_ff != ST_OK) |=>
         (rsp_page_ff == 4'd0 && rsp_block_ff == 6'd0 && rsp_count_ff == 7'd0 &&
          rsp_offset_ff == 16'd0))
      else $error("error result carries nonzero fields");

endmodule

`default_nettype wire

// ----- rtl/core/page_bitmap_run_allocator_unit.sv -----
`default_nettype none
// allocate: request transfer, check, a page scan that passes over one page per cycle, run
//   search, mark, longest-run recount, then result valid; a release marks in its check and
//   then recounts; too large and bad range go from check, no fit from scan, to the result
// one item at a time; the run search takes 7 steps and the longest-run recount 8 byte lanes;
//   a stalled result only holds the next item in its finish state
// reset: synchronous; all pages free with longest run 64, no result pending, ready at once

module page_bitmap_run_allocator_unit
   import pbra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // size_bytes[19:0], page_index[23:20],
                                        // first_block[29:24], block_count[36:30], zero pad
   input  wire logic [0:0]  req_tuser,  // cmd[0]: 0 allocate, 1 release
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // page_index_out[3:0], first_block_out[9:4],
                                        // blocks_used[16:10], byte_offset[32:17], zero pad
   output logic [1:0]       rsp_tuser   // status[1:0]
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   status_type  rsp_status;
   logic [3:0]  rsp_page_index_out;
   logic [5:0]  rsp_first_block_out;
   logic [6:0]  rsp_blocks_used;
   logic [15:0] rsp_byte_offset;

   // sequencer: check, scan, fit search, mark, longest-run recount, result handoff
   pbra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // page bitmaps, run search and result register
   pbra_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_cmd             (req_tuser[0]),
      .req_size_bytes      (req_tdata[19:0]),
      .req_page_index      (req_tdata[23:20]),
      .req_first_block     (req_tdata[29:24]),
      .req_block_count     (req_tdata[36:30]),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_status          (rsp_status),
      .rsp_page_index_out  (rsp_page_index_out),
      .rsp_first_block_out (rsp_first_block_out),
      .rsp_blocks_used     (rsp_blocks_used),
      .rsp_byte_offset     (rsp_byte_offset)
   );

   // pack the result transfer
   assign rsp_tdata = {7'd0, rsp_byte_offset, rsp_blocks_used, rsp_first_block_out,
                       rsp_page_index_out};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import pbra_pkg::*;

   // run limits
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
   localparam int DRAIN_CYCLES   = 40;    // longest allocate latency plus margin
   localparam int MAX_SIZE       = 20'hFFFFF;

   // one request as the block sees it
   typedef struct packed {
      cmd_type     cmd;
      logic [19:0] size_bytes;
      logic [3:0]  page_index;
      logic [5:0]  first_block;
      logic [6:0]  block_count;
   } alloc_req_type;

   // one result, field by field
   typedef struct packed {
      status_type  status;
      logic [3:0]  page;
      logic [5:0]  block;
      logic [6:0]  blocks;
      logic [15:0] offset;
   } alloc_rsp_type;

   // a run handed out by the allocator and not yet given back
   typedef struct {
      int page;
      int first;
      int count;
   } block_run_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;  // size_bytes, page_index, first_block, block_count, zero pad
   logic [0:0]  req_tuser   = '0;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;         // page_index_out, first_block_out, blocks_used, byte_offset
   logic [1:0]  rsp_tuser;         // status

   // shadow copy of the pool state
   logic [63:0] page_bitmap [NUM_PAGES];
   int          page_longest[NUM_PAGES];

   alloc_rsp_type pending_rsp_q[$];
   block_run_type live_runs[$];

   int gap_limit   = 12;  // both sides draw their idle cycles from 0 to this
   int fault_count = 0;
   int idle_cycles = 0;

   page_bitmap_run_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // pool predictor
   // ------------------------------------------------------------------

   // contiguous ones of the given length starting at a block
   function automatic logic [63:0] run_bits(int count, int first);
      logic [63:0] m;
      m = (count >= 64) ? {64{1'b1}} : ((64'd1 << count) - 64'd1);
      return m << first;
   endfunction

   function automatic int longest_free(logic [63:0] map);
      int best;
      int cur;
      best = 0;
      cur  = 0;
      for (int i = 0; i < BLOCKS_PER_PAGE; i++) begin
         if (!map[i]) begin
            cur++;
            if (cur > best) best = cur;
         end else begin
            cur = 0;
         end
      end
      return best;
   endfunction

   // lowest block that opens a free run of count blocks
   function automatic int lowest_fit(logic [63:0] map, int count);
      int start;
      int streak;
      start  = 0;
      streak = 0;
      for (int i = 0; i < BLOCKS_PER_PAGE; i++) begin
         if (!map[i]) begin
            streak++;
            if (streak >= count) break;
         end else begin
            start  = i + 1;
            streak = 0;
         end
      end
      return start;
   endfunction

   // updates the shadow pool and returns the result the block owes
   function automatic alloc_rsp_type pool_outcome(alloc_req_type r);
      alloc_rsp_type o;
      int need;
      int pg;
      int blk;
      int cnt;
      o = '0;
      o.status = ST_OK;
      if (r.cmd == CMD_ALLOC) begin
         need = (int'(r.size_bytes) + HDR_BYTES) / BLOCK_BYTES + 1;
         if (need > BLOCKS_PER_PAGE) begin
            o.status = ST_TOO_LARGE;
            return o;
         end
         // first page whose longest free run is long enough
         pg = -1;
         for (int p = 0; p < NUM_PAGES; p++)
            if (pg < 0 && page_longest[p] >= need) pg = p;
         if (pg < 0) begin
            o.status = ST_NO_FIT;
            return o;
         end
         blk = lowest_fit(page_bitmap[pg], need);
         cnt = need;
         page_bitmap[pg]  = page_bitmap[pg] | run_bits(cnt, blk);
         page_longest[pg] = longest_free(page_bitmap[pg]);
      end else begin
         pg  = int'(r.page_index);
         blk = int'(r.first_block);
         cnt = int'(r.block_count);
         if (pg >= NUM_PAGES || cnt == 0 || cnt > BLOCKS_PER_PAGE ||
             blk + cnt > BLOCKS_PER_PAGE) begin
            o.status = ST_BAD_RANGE;
            return o;
         end
         // already free blocks just stay free
         page_bitmap[pg]  = page_bitmap[pg] & ~run_bits(cnt, blk);
         page_longest[pg] = longest_free(page_bitmap[pg]);
      end
      o.page   = 4'(pg);
      o.block  = 6'(blk);
      o.blocks = 7'(cnt);
      o.offset = 16'(pg * PAGE_BYTES + blk * BLOCK_BYTES + HDR_BYTES);
      return o;
   endfunction

   initial begin
      for (int p = 0; p < NUM_PAGES; p++) begin
         page_bitmap[p]  = '0;
         page_longest[p] = BLOCKS_PER_PAGE;
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   function automatic alloc_req_type alloc_of(int size);
      alloc_req_type r;
      r = '0;
      r.cmd = CMD_ALLOC;
      r.size_bytes = 20'(size);
      return r;
   endfunction

   function automatic alloc_req_type release_of(int page, int first, int count);
      alloc_req_type r;
      r = '0;
      r.cmd         = CMD_RELEASE;
      r.page_index  = 4'(page);
      r.first_block = 6'(first);
      r.block_count = 7'(count);
      return r;
   endfunction

   // presents one request, returns at the edge of its transfer
   // valid stays high so a back-to-back request needs no second assignment
   task automatic send_request(input alloc_req_type r, output alloc_rsp_type o);
      int gap;
      block_run_type run;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {3'b000, r.block_count, r.first_block, r.page_index, r.size_bytes};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = pool_outcome(r);
      pending_rsp_q.push_back(o);
      if (r.cmd == CMD_ALLOC && o.status == ST_OK) begin
         run.page  = int'(o.page);
         run.first = int'(o.block);
         run.count = int'(o.blocks);
         live_runs.push_back(run);
      end
   endtask

   task automatic send(input alloc_req_type r);
      alloc_rsp_type ignored;
      send_request(r, ignored);
   endtask

   // ------------------------------------------------------------------
   // result side: random stalls, each transfer checked against the oldest expectation
   // ------------------------------------------------------------------

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fault_count++;
      end
   endtask

   initial begin
      int stall;
      alloc_rsp_type want;
      wait (reset == 1'b0);
      forever begin
         stall = $urandom_range(0, gap_limit);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (pending_rsp_q.size() == 0) begin
            $display("%0t ns: result with none expected, expected none, actual status %0d",
                     $time, rsp_tuser);
            fault_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("status", int'(want.status), int'(rsp_tuser));
            check_field("page_index_out", int'(want.page), int'(rsp_tdata[3:0]));
            check_field("first_block_out", int'(want.block), int'(rsp_tdata[9:4]));
            check_field("blocks_used", int'(want.blocks), int'(rsp_tdata[16:10]));
            check_field("byte_offset", int'(want.offset), int'(rsp_tdata[32:17]));
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long with no transfer means the block hung
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // block count rounding at the header boundary and the too-large cutoff
   task automatic test_size_edges();
      send(alloc_of(0));         // one block
      send(alloc_of(47));        // still one block with the header
      send(alloc_of(48));        // header pushes it to two
      send(alloc_of(4079));      // exactly a full page
      send(alloc_of(4080));      // one block over a page
      send(alloc_of(MAX_SIZE));  // largest size field
   endtask

   // bad release ranges, a full-page release and a release of free blocks
   task automatic test_release_ranges();
      send(release_of(3, 0, 0));     // zero count
      send(release_of(3, 0, 127));   // count beyond a page
      send(release_of(3, 63, 2));    // run past the page end
      send(release_of(0, 0, 64));    // whole page back
      send(release_of(1, 63, 1));    // last block of a full page
      send(release_of(5, 63, 1));    // block that was never allocated
   endtask

   // fill every page, then ask for more
   task automatic test_pool_exhaustion();
      alloc_rsp_type o;
      int tries;
      tries = 0;
      do begin
         send_request(alloc_of(4079), o);
         tries++;
      end while (o.status != ST_NO_FIT && tries < NUM_PAGES + 4);
      send(alloc_of(0));              // fills the one block left
      send(alloc_of(0));              // nothing left at all
      send(release_of(9, 10, 3));     // hole in the middle of a page
      send(alloc_of(100));            // two blocks land at the hole
   endtask

   // random traffic mostly made of real allocate and release pairs
   task automatic test_random_churn(input int items, input int alloc_pct, input int idle_max);
      alloc_req_type r;
      block_run_type run;
      int pick;
      int kind;
      int first;
      gap_limit = idle_max;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < alloc_pct) begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
               r = alloc_of($urandom_range(0, 600));
            else if (kind < 90)
               r = alloc_of($urandom_range(0, 4079));
            else if (kind < 97)
               r = alloc_of($urandom_range(0, MAX_SIZE));
            else
               r = alloc_of($urandom_range(4000, 4100));
         end else begin
            kind = $urandom_range(0, 99);
            if (live_runs.size() > 0 && kind < 80) begin
               pick = $urandom_range(0, live_runs.size() - 1);
               run  = live_runs[pick];
               live_runs.delete(pick);
               if (kind < 70) begin
                  r = release_of(run.page, run.first, run.count);
               end else begin
                  // part of a run, the rest stays in use
                  first = run.first + $urandom_range(0, run.count - 1);
                  r = release_of(run.page, first,
                                 $urandom_range(1, run.first + run.count - first));
               end
            end else begin
               r = release_of($urandom_range(0, NUM_PAGES - 1), $urandom_range(0, 63),
                              $urandom_range(0, 127));
            end
         end
         send(r);
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_size_edges();
      test_release_ranges();
      test_pool_exhaustion();
      test_random_churn(300, 75, 12);  // fills the pool up to no-fit
      test_random_churn(200, 30, 12);  // drains it again
      test_random_churn(150, 60, 0);   // back to back on both sides
      test_random_churn(200, 55, 12);

      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ----- page_bitmap_run_allocator_unit.f -----
rtl/core/pbra_pkg.sv
rtl/core/pbra_ctrl.sv
rtl/core/pbra_dpath.sv
rtl/core/page_bitmap_run_allocator_unit.sv
sim/testbench.sv
